@@ rtl/tcaa_pkg.sv @@
// ----------------------------------------------------------------------------
// tcaa_pkg: shared types and constants of the two-class alternating arbiter
// beat payloads, holder codes, action codes and controller states
// ----------------------------------------------------------------------------
package tcaa_pkg;

  localparam int TAG_WIDTH         = 8;
  localparam int QUEUE_DEPTH_DFLT  = 16;

  // action codes
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // holder codes
  typedef enum logic [1:0] {
    HOLD_FREE = 2'd0,
    HOLD_C0   = 2'd1,
    HOLD_C1   = 2'd2
  } holder_t;

  typedef struct packed {
    logic                 action;
    logic                 category;
    logic [TAG_WIDTH-1:0] requester_tag;
  } in_item_t;

  typedef struct packed {
    logic                 grant_valid;
    logic [TAG_WIDTH-1:0] grant_tag;
    logic                 grant_category;
    logic [1:0]           holder;
    logic                 dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

@@ rtl/tcaa_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcaa_ctrl: controller of the two-class alternating arbiter
// sequences accept, execute and result delivery of one beat at a time
// ----------------------------------------------------------------------------
module tcaa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output tcaa_pkg::dp_cmd_t cmd
);

  tcaa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcaa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcaa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tcaa_pkg::ST_EXEC;
      end
      tcaa_pkg::ST_EXEC: begin
        state_nxt = tcaa_pkg::ST_OUT;
      end
      tcaa_pkg::ST_OUT: begin
        if (out_ready) state_nxt = tcaa_pkg::ST_IDLE;
      end
      default: state_nxt = tcaa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      tcaa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tcaa_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      tcaa_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/tcaa_dp.sv @@
// ----------------------------------------------------------------------------
// tcaa_dp: datapath of the two-class alternating arbiter
// holder register, two circular tag queues and the grant decision
// ----------------------------------------------------------------------------
module tcaa_dp #(
  parameter int QUEUE_DEPTH = tcaa_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcaa_pkg::dp_cmd_t   cmd,
  input  tcaa_pkg::in_item_t  in_item,
  output tcaa_pkg::out_item_t out_item
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int TW    = tcaa_pkg::TAG_WIDTH;

  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);

  tcaa_pkg::in_item_t  item_r;
  tcaa_pkg::out_item_t out_r, out_nxt;
  tcaa_pkg::holder_t   holder_r, holder_nxt;

  logic [IDX_W-1:0] head0_r, head0_nxt, head1_r, head1_nxt;
  logic [CNT_W-1:0] cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [TW-1:0]    q0 [QUEUE_DEPTH];
  logic [TW-1:0]    q1 [QUEUE_DEPTH];
  logic [TW-1:0]    rd0_r, rd1_r;

  logic             push0, push1;
  logic [IDX_W-1:0] tail0, tail1;
  logic [SUM_W-1:0] sum0, sum1;
  logic             own, other;
  logic             other_nonempty, own_nonempty;
  logic             pop0, pop1;

  // tail index: head plus count, wrapped once
  always_comb begin
    sum0  = SUM_W'(head0_r) + SUM_W'(cnt0_r);
    sum1  = SUM_W'(head1_r) + SUM_W'(cnt1_r);
    if (sum0 >= SUM_DEPTH) sum0 = sum0 - SUM_DEPTH;
    if (sum1 >= SUM_DEPTH) sum1 = sum1 - SUM_DEPTH;
    tail0 = sum0[IDX_W-1:0];
    tail1 = sum1[IDX_W-1:0];
  end

  assign own            = (holder_r == tcaa_pkg::HOLD_C0) ? 1'b0 : 1'b1;
  assign other          = ~own;
  assign other_nonempty = other ? (cnt1_r != '0) : (cnt0_r != '0);
  assign own_nonempty   = own   ? (cnt1_r != '0) : (cnt0_r != '0);

  always_comb begin
    out_nxt    = '0;
    holder_nxt = holder_r;
    push0      = 1'b0;
    push1      = 1'b0;
    pop0       = 1'b0;
    pop1       = 1'b0;
    priority if (item_r.action == tcaa_pkg::ACT_REQUEST) begin
      if (holder_r == tcaa_pkg::HOLD_FREE) begin
        holder_nxt             = item_r.category ? tcaa_pkg::HOLD_C1 : tcaa_pkg::HOLD_C0;
        out_nxt.grant_valid    = 1'b1;
        out_nxt.grant_tag      = item_r.requester_tag;
        out_nxt.grant_category = item_r.category;
      end else if (item_r.category) begin
        if (cnt1_r == CNT_FULL) out_nxt.dropped = 1'b1;
        else                    push1 = 1'b1;
      end else begin
        if (cnt0_r == CNT_FULL) out_nxt.dropped = 1'b1;
        else                    push0 = 1'b1;
      end
    end else if (holder_r != tcaa_pkg::HOLD_FREE) begin
      if (other_nonempty) begin
        holder_nxt             = other ? tcaa_pkg::HOLD_C1 : tcaa_pkg::HOLD_C0;
        out_nxt.grant_valid    = 1'b1;
        out_nxt.grant_tag      = other ? rd1_r : rd0_r;
        out_nxt.grant_category = other;
        pop0                   = ~other;
        pop1                   = other;
      end else if (own_nonempty) begin
        holder_nxt             = own ? tcaa_pkg::HOLD_C1 : tcaa_pkg::HOLD_C0;
        out_nxt.grant_valid    = 1'b1;
        out_nxt.grant_tag      = own ? rd1_r : rd0_r;
        out_nxt.grant_category = own;
        pop0                   = ~own;
        pop1                   = own;
      end else begin
        holder_nxt = tcaa_pkg::HOLD_FREE;
      end
    end else begin
      // release while free: stays free, nothing granted
      holder_nxt = tcaa_pkg::HOLD_FREE;
    end
    out_nxt.holder = holder_nxt;
  end

  always_comb begin
    head0_nxt = head0_r;
    head1_nxt = head1_r;
    cnt0_nxt  = cnt0_r;
    cnt1_nxt  = cnt1_r;
    if (pop0) begin
      head0_nxt = (head0_r == IDX_LAST) ? '0 : head0_r + IDX_W'(1);
      cnt0_nxt  = cnt0_r - CNT_W'(1);
    end
    if (pop1) begin
      head1_nxt = (head1_r == IDX_LAST) ? '0 : head1_r + IDX_W'(1);
      cnt1_nxt  = cnt1_r - CNT_W'(1);
    end
    if (push0) cnt0_nxt = cnt0_r + CNT_W'(1);
    if (push1) cnt1_nxt = cnt1_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_r <= tcaa_pkg::HOLD_FREE;
      head0_r  <= '0;
      head1_r  <= '0;
      cnt0_r   <= '0;
      cnt1_r   <= '0;
    end else if (cmd.exec) begin
      holder_r <= holder_nxt;
      head0_r  <= head0_nxt;
      head1_r  <= head1_nxt;
      cnt0_r   <= cnt0_nxt;
      cnt1_r   <= cnt1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) out_r  <= out_nxt;
  end

  // queue storage, head entries read every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && push0) q0[tail0] <= item_r.requester_tag;
    rd0_r <= q0[head0_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push1) q1[tail1] <= item_r.requester_tag;
    rd1_r <= q1[head1_r];
  end

  assign out_item = out_r;

endmodule

@@ rtl/two_class_alternating_arbiter_top.sv @@
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter_top: two-class alternating arbiter
// grants one shared resource to tags from two classes with per-class queues
// ----------------------------------------------------------------------------
// usage
//   in channel : in_valid / in_ready, in_item = action, category, tag
//                a request grants at once when free, else queues the tag in
//                its class queue (dropped and flagged when that queue is full)
//                a release hands over to the other class's oldest tag, then
//                the own class's oldest tag, else frees the resource
//   out channel: out_valid / out_ready, exactly one result beat per input
//                beat: grant valid, tag, class, new holder, dropped
//   sequence   : the input beat is registered on accept, the execute state
//                registers the result, then the result beat is offered;
//                the controller walks accept, execute and deliver in turn,
//                so no new beat is taken before the result has left,
//                because the queue head read is a registered memory read
//   reset      : rst_n low clears holder to free and both queues to empty;
//                queue storage itself is not cleared, no clearing pass
//   stall      : while out_ready is low the result holds and in_ready stays
//                low, so no new beat is accepted until the result is taken
// ----------------------------------------------------------------------------
module two_class_alternating_arbiter_top #(
  parameter int QUEUE_DEPTH = tcaa_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcaa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tcaa_pkg::out_item_t out_item
);

  // command bundle from controller to datapath
  tcaa_pkg::dp_cmd_t cmd;

  tcaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // queues, holder and the decision logic
  tcaa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ rtl/tcaa_checker.sv @@
// ----------------------------------------------------------------------------
// tcaa_checker: port-level checks of the two-class alternating arbiter
// watches handshakes and result consistency, bound to the top level
// ----------------------------------------------------------------------------
module tcaa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tcaa_pkg::out_item_t out_item
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // one beat in flight: no accept while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input accepted while result pending");

  // accepted beat blocks the input until its result leaves
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // a grant always leaves the resource held, never with a drop
  a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.grant_valid |->
      out_item.holder != tcaa_pkg::HOLD_FREE && !out_item.dropped)
    else $error("grant without holder or with drop");

  // a drop only happens while the resource is busy
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.dropped |->
      out_item.holder == tcaa_pkg::HOLD_C0 || out_item.holder == tcaa_pkg::HOLD_C1)
    else $error("drop while free");

endmodule

bind two_class_alternating_arbiter_top tcaa_checker u_tcaa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

@@ tb/sv/tcaa_grant_checker.sv @@
// ----------------------------------------------------------------------------
// tcaa_grant_checker: result checker of the two-class alternating arbiter
// predicts the grant beat for every accepted input beat and compares each
// result beat with the oldest prediction
// ----------------------------------------------------------------------------
module tcaa_grant_checker #(
  parameter int QUEUE_DEPTH = tcaa_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tcaa_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tcaa_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  beats_in,
  output int                  grants,
  output int                  drops,
  output int                  idle_releases,
  output int                  deepest
);

  timeunit 1ns;
  timeprecision 1ps;

  tcaa_pkg::holder_t              held = tcaa_pkg::HOLD_FREE;
  logic [tcaa_pkg::TAG_WIDTH-1:0] wait_c0[$];
  logic [tcaa_pkg::TAG_WIDTH-1:0] wait_c1[$];
  tcaa_pkg::out_item_t            grant_due[$];
  int                             errors = 0;
  int                             n_beats = 0;
  int                             n_grants = 0;
  int                             n_drops = 0;
  int                             n_idle_rel = 0;
  int                             max_depth = 0;

  function automatic tcaa_pkg::out_item_t predict_grant(input tcaa_pkg::in_item_t beat);
    tcaa_pkg::out_item_t r;
    r = '0;
    if (beat.action == tcaa_pkg::ACT_REQUEST) begin
      if (held == tcaa_pkg::HOLD_FREE) begin
        held = beat.category ? tcaa_pkg::HOLD_C1 : tcaa_pkg::HOLD_C0;
        r.grant_valid    = 1'b1;
        r.grant_tag      = beat.requester_tag;
        r.grant_category = beat.category;
      end else if (beat.category == 1'b0) begin
        if (wait_c0.size() < QUEUE_DEPTH) wait_c0.push_back(beat.requester_tag);
        else r.dropped = 1'b1;
      end else begin
        if (wait_c1.size() < QUEUE_DEPTH) wait_c1.push_back(beat.requester_tag);
        else r.dropped = 1'b1;
      end
    end else if (held == tcaa_pkg::HOLD_FREE) begin
      n_idle_rel++;
    end else if (held == tcaa_pkg::HOLD_C0) begin
      // other class first, then own class, else free
      if (wait_c1.size() != 0) begin
        r.grant_valid    = 1'b1;
        r.grant_tag      = wait_c1.pop_front();
        r.grant_category = 1'b1;
        held             = tcaa_pkg::HOLD_C1;
      end else if (wait_c0.size() != 0) begin
        r.grant_valid    = 1'b1;
        r.grant_tag      = wait_c0.pop_front();
        r.grant_category = 1'b0;
      end else begin
        held = tcaa_pkg::HOLD_FREE;
      end
    end else begin
      if (wait_c0.size() != 0) begin
        r.grant_valid    = 1'b1;
        r.grant_tag      = wait_c0.pop_front();
        r.grant_category = 1'b0;
        held             = tcaa_pkg::HOLD_C0;
      end else if (wait_c1.size() != 0) begin
        r.grant_valid    = 1'b1;
        r.grant_tag      = wait_c1.pop_front();
        r.grant_category = 1'b1;
        held             = tcaa_pkg::HOLD_C1;
      end else begin
        held = tcaa_pkg::HOLD_FREE;
      end
    end
    r.holder = held;
    if (wait_c0.size() > max_depth) max_depth = wait_c0.size();
    if (wait_c1.size() > max_depth) max_depth = wait_c1.size();
    return r;
  endfunction

  always @(posedge clk) begin
    tcaa_pkg::out_item_t exp_beat;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        exp_beat = predict_grant(in_item);
        grant_due.push_back(exp_beat);
        n_beats++;
        if (exp_beat.grant_valid) n_grants++;
        if (exp_beat.dropped) n_drops++;
      end
      if (out_valid && out_ready) begin
        if (grant_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result gv=%0b tag=%02h cat=%0b holder=%0d drop=%0b",
                     $realtime, out_item.grant_valid, out_item.grant_tag,
                     out_item.grant_category, out_item.holder, out_item.dropped);
        end else begin
          exp_beat = grant_due.pop_front();
          if (out_item.grant_valid !== exp_beat.grant_valid ||
              out_item.grant_tag !== exp_beat.grant_tag ||
              out_item.grant_category !== exp_beat.grant_category ||
              out_item.holder !== exp_beat.holder ||
              out_item.dropped !== exp_beat.dropped) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp gv=%0b tag=%02h cat=%0b holder=%0d drop=%0b",
                       $realtime, exp_beat.grant_valid, exp_beat.grant_tag,
                       exp_beat.grant_category, exp_beat.holder, exp_beat.dropped);
              $display("%0t:          got gv=%0b tag=%02h cat=%0b holder=%0d drop=%0b",
                       $realtime, out_item.grant_valid, out_item.grant_tag,
                       out_item.grant_category, out_item.holder, out_item.dropped);
            end
          end
        end
      end
    end
    fail_count    <= errors;
    pending       <= grant_due.size();
    beats_in      <= n_beats;
    grants        <= n_grants;
    drops         <= n_drops;
    idle_releases <= n_idle_rel;
    deepest       <= max_depth;
  end

endmodule

@@ tb/sv/two_class_alternating_arbiter_top_test.sv @@
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter_top_test: testbench of the alternating arbiter
// drives directed and random request/release beats under changing sender
// gaps and receiver stalls; a checker beside the block predicts every grant
// ----------------------------------------------------------------------------
module two_class_alternating_arbiter_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = tcaa_pkg::QUEUE_DEPTH_DFLT;
  localparam int TW    = tcaa_pkg::TAG_WIDTH;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tcaa_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  tcaa_pkg::out_item_t out_item;

  int fail_count, pending, beats_in, grants, drops, idle_releases, deepest;

  // idling knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;

  always #4 clk = ~clk;

  two_class_alternating_arbiter_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  tcaa_grant_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_in      (beats_in),
    .grants        (grants),
    .drops         (drops),
    .idle_releases (idle_releases),
    .deepest       (deepest)
  );

  // receiver: one fresh ready decision per edge
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic tcaa_pkg::in_item_t make_beat(input logic act, input logic cat,
                                                   input logic [TW-1:0] tag);
    tcaa_pkg::in_item_t b;
    b.action        = act;
    b.category      = cat;
    b.requester_tag = tag;
    return b;
  endfunction

  // present one beat and hold it until accepted; valid is only lowered when a
  // gap cycle follows, so valid never gets two updates in one step
  task automatic send_beat(input tcaa_pkg::in_item_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= tcaa_pkg::in_item_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random traffic in short blocks, each with its own request/release mix
  // and class bias so that queues fill up, run dry and alternate
  task automatic run_random(input int n_beats);
    int req_pct;
    int c1_pct;
    tcaa_pkg::in_item_t b;
    req_pct = 50;
    c1_pct  = 50;
    for (int i = 0; i < n_beats; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(3))
          0: req_pct = 25;
          1: req_pct = 50;
          2: req_pct = 62;
          default: req_pct = 85;
        endcase
        case ($urandom_range(2))
          0: c1_pct = 10;
          1: c1_pct = 50;
          default: c1_pct = 90;
        endcase
      end
      b.action        = ($urandom_range(99) < req_pct) ? tcaa_pkg::ACT_REQUEST
                                                        : tcaa_pkg::ACT_RELEASE;
      b.category      = ($urandom_range(99) < c1_pct);
      b.requester_tag = TW'($urandom_range(255));
      send_beat(b);
    end
  endtask

  initial begin
    // reset held low at the start, then released
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    // release while free, category set on release is ignored
    send_beat(make_beat(tcaa_pkg::ACT_RELEASE, 1'b1, 8'hff));
    // request while free grants at once
    send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b0, 8'hff));
    // requests of both classes while busy queue
    send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b0, 8'h00));
    send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b1, 8'h55));
    // release hands over to the other class each time, then frees
    send_beat(make_beat(tcaa_pkg::ACT_RELEASE, 1'b0, 8'h00));
    send_beat(make_beat(tcaa_pkg::ACT_RELEASE, 1'b1, 8'haa));
    send_beat(make_beat(tcaa_pkg::ACT_RELEASE, 1'b0, 8'h00));
    // class 1 takes it, then class 0 queue is filled to the brim
    send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b1, 8'haa));
    for (int i = 0; i < DEPTH; i++)
      send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b0, TW'(i * 17)));
    // request into a full queue is dropped
    send_beat(make_beat(tcaa_pkg::ACT_REQUEST, 1'b0, 8'h3c));

    // random part in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      run_random(325);
    end

    // drain: let every predicted result come out
    in_valid  <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d beats: %0d grants, %0d dropped requests, %0d releases while free",
             beats_in, grants, drops, idle_releases);
    $display("deepest class queue reached %0d of %0d entries", deepest, DEPTH);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
